/* hw/rtl/dcbn_pkg.sv */
// Shared constants, types and the tube decode table for the daisy-chain tube driver.
package dcbn_pkg;

    localparam logic [7:0] END_MARK    = 8'hFF;
    localparam logic [7:0] EMPTY_MARK  = 8'hF0;
    localparam logic [3:0] BLANK_DIGIT = 4'd10;

    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int LINES   = 4;
    localparam int TDATA_W = 24;
    localparam int TUSER_W = 2;

    typedef struct packed {
        logic [LINES-1:0] drive;
        logic [LINES-1:0] level;
    } tube_t;

    typedef struct packed {
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               display_changed;
        logic [DIGIT_W-1:0] tens_digit;
        logic [DIGIT_W-1:0] units_digit;
    } chain_result_t;

    // One line is driven high (level and drive set) and one low (drive only); the blank digit drives none.
    function automatic tube_t decode_digit(input logic [DIGIT_W-1:0] digit);
        tube_t t;
        case (digit)
            4'd0:    t = '{drive: 4'b0101, level: 4'b0100};
            4'd1:    t = '{drive: 4'b1010, level: 4'b1000};
            4'd2:    t = '{drive: 4'b0011, level: 4'b0001};
            4'd3:    t = '{drive: 4'b0011, level: 4'b0010};
            4'd4:    t = '{drive: 4'b1100, level: 4'b0100};
            4'd5:    t = '{drive: 4'b1010, level: 4'b0010};
            4'd6:    t = '{drive: 4'b0110, level: 4'b0010};
            4'd7:    t = '{drive: 4'b0101, level: 4'b0001};
            4'd8:    t = '{drive: 4'b1001, level: 4'b1000};
            4'd9:    t = '{drive: 4'b1001, level: 4'b0001};
            BLANK_DIGIT: t = '{drive: 4'b0000, level: 4'b0000};
            default: t = '{drive: 4'b0101, level: 4'b0100};
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/daisy_chain_bcd_nixie_driver_top.sv */
// Top level of the daisy-chain tube driver: input register, chain logic and result register.
// Each accepted input goes via the input register and chain logic into the result register.
// Throughput: one transaction per cycle while results are taken, set by the single-register
// hold and table decode. A waiting result stalls the input once the input register holds a
// transaction. Reset is asynchronous and active low: the hold empties and both tubes blank.
module daisy_chain_bcd_nixie_driver_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: rx_byte[7:0]
    input  logic [dcbn_pkg::BYTE_W-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: tx_byte[7:0], tens_drive[11:8], tens_level[15:12],
    // units_drive[19:16], units_level[23:20]
    output logic [dcbn_pkg::TDATA_W-1:0] m_axis_tdata,
    // tuser: tx_valid[0], display_changed[1]
    output logic [dcbn_pkg::TUSER_W-1:0] m_axis_tuser
);
    import dcbn_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic [TUSER_W-1:0] out_user_reg, out_user_next;
    logic              advance;
    chain_result_t     result;
    tube_t             tens_tube;
    tube_t             units_tube;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    dcbn_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    dcbn_decode u_tens (
        .digit (result.tens_digit),
        .tube  (tens_tube)
    );

    dcbn_decode u_units (
        .digit (result.units_digit),
        .tube  (units_tube)
    );

    assign out_data_next = {units_tube.level, units_tube.drive,
                            tens_tube.level, tens_tube.drive, result.tx_byte};
    assign out_user_next = {result.display_changed, result.tx_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* hw/rtl/dcbn_decode.sv */
// Decoder from one tube digit to its four tri-state line enables and levels.
module dcbn_decode (
    input  logic [dcbn_pkg::DIGIT_W-1:0] digit,
    output dcbn_pkg::tube_t              tube
);
    import dcbn_pkg::*;

    always_comb
    begin
        tube = decode_digit(digit);
    end

endmodule

/* hw/rtl/dcbn_chain.sv */
// Chain hold register, frame-end detection and digit latches.
module dcbn_chain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic [dcbn_pkg::BYTE_W-1:0] rx_byte,
    output dcbn_pkg::chain_result_t     result
);
    import dcbn_pkg::*;

    logic [BYTE_W-1:0]  held_reg, held_next;
    logic [DIGIT_W-1:0] tens_reg, tens_next;
    logic [DIGIT_W-1:0] units_reg, units_next;

    always_comb
    begin
        held_next  = rx_byte;
        tens_next  = tens_reg;
        units_next = units_reg;
        result     = '0;
        if (rx_byte == END_MARK)
        begin
            held_next              = EMPTY_MARK;
            tens_next              = held_reg[BYTE_W-1:DIGIT_W];
            units_next             = held_reg[DIGIT_W-1:0];
            result.tx_valid        = 1'b1;
            result.tx_byte         = END_MARK;
            result.display_changed = 1'b1;
        end
        else if (held_reg != EMPTY_MARK)
        begin
            result.tx_valid = 1'b1;
            result.tx_byte  = held_reg;
        end
        result.tens_digit  = tens_next;
        result.units_digit = units_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= EMPTY_MARK;
            tens_reg  <= BLANK_DIGIT;
            units_reg <= BLANK_DIGIT;
        end
        else if (step_en)
        begin
            held_reg  <= held_next;
            tens_reg  <= tens_next;
            units_reg <= units_next;
        end
    end

endmodule

/* hw/rtl/dcbn_checker.sv */
// Port-level checker for the daisy-chain tube driver, bound to the top level.
module dcbn_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [dcbn_pkg::BYTE_W-1:0]  s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [dcbn_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [dcbn_pkg::TUSER_W-1:0] m_axis_tuser
);
    import dcbn_pkg::*;

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Nothing forwarded means a zero byte.
    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
        else $error("byte present without forwarding");

    // A frame end always forwards the end mark.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tuser[0] && m_axis_tdata[7:0] == END_MARK)
        else $error("frame end without forwarded end mark");

    // A line is high only where driven, and a tube drives two lines or none.
    a_tube_lines: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[15:12] & ~m_axis_tdata[11:8]) == 4'b0000 &&
            (m_axis_tdata[23:20] & ~m_axis_tdata[19:16]) == 4'b0000 &&
            ($countones(m_axis_tdata[11:8]) == 0 || $countones(m_axis_tdata[11:8]) == 2) &&
            ($countones(m_axis_tdata[19:16]) == 0 || $countones(m_axis_tdata[19:16]) == 2))
        else $error("illegal tube line pattern");

endmodule

bind daisy_chain_bcd_nixie_driver_top dcbn_checker u_dcbn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
